[src/maze_dfs_carver_unit_assert.svh]
// assertion helpers included by the carver rtl
`ifndef MAZE_DFS_CARVER_UNIT_ASSERT_SVH
`define MAZE_DFS_CARVER_UNIT_ASSERT_SVH

// checked only while out of reset
`define MDC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MDC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/mdc_pkg.sv]
package mdc_pkg;

  localparam int unsigned MAX_COLS_DEF = 32;
  localparam int unsigned MAX_ROWS_DEF = 32;

  localparam int unsigned GridW    = 6;
  localparam int unsigned CoordW   = 5;
  localparam int unsigned RandW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  localparam logic [CfgIdxW-1:0] REG_GRID_COLS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_START_COL = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_START_ROW = 2'd3;

  typedef logic [1:0] dir_t;

  localparam dir_t DIR_NORTH = 2'd0;
  localparam dir_t DIR_EAST  = 2'd1;
  localparam dir_t DIR_SOUTH = 2'd2;
  localparam dir_t DIR_WEST  = 2'd3;

  typedef struct packed {
    logic found;
    dir_t dir;
  } pick_t;

endpackage

[src/maze_dfs_carver_unit.sv]
// randomized depth-first maze carver, one carving step per input beat
// input channel: rand_pick_i with in_valid_i / in_stall_o; each beat is one step request
// output channel: carved_o, from_col_o, from_row_o, wall_dir_o, done_res_o with
//   out_valid_o / out_stall_i; exactly one result beat per step
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; always ready
//   (0 grid_cols, 1 grid_rows, 2 start_col, 3 start_row), write only while idle
// after reset the visited map is swept clear, one cell per cycle, covering all
//   2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) addresses (1024 at the defaults); steps are held
//   off by in_stall_o during the sweep, config writes are still taken
// a step without backtracking runs through these states after it is accepted:
//   the four neighbour visited bits come out of the single read port of the visited
//   ram one per cycle (S_SCAN), S_SCAN_LAST collects the last read, then S_EVAL
//   evaluates and S_OUT loads the output register; the block returns to S_IDLE
//   before it accepts the next step, so steps do not overlap
// the very first step first marks the start cell in S_INIT_RD and S_INIT_WR (only
//   S_INIT_RD when the start cell lies off the grid); each cell popped while backtracking
//   adds a stack ram read (S_POP) plus a fresh neighbour scan
// a new step is accepted as soon as the previous one has been handed to the output
//   register, even when that result is still stalled; a stalled result holds and the
//   next result waits in the block until the output register frees up
module maze_dfs_carver_unit #(
  parameter int unsigned MAX_COLS = mdc_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = mdc_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mdc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mdc_pkg::CfgDataW-1:0] cfg_data_i,
  // step requests
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mdc_pkg::RandW-1:0]    rand_pick_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         carved_o,
  output logic [mdc_pkg::CoordW-1:0]   from_col_o,
  output logic [mdc_pkg::CoordW-1:0]   from_row_o,
  output logic [1:0]                   wall_dir_o,
  output logic                         done_res_o
);

  import mdc_pkg::*;

  `include "maze_dfs_carver_unit_assert.svh"

  localparam int unsigned COL_W      = $clog2(MAX_COLS);
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
  // current cell keeps the full start coordinate so an off-grid start stays off-grid
  localparam int unsigned CUR_CW     = (COL_W > CoordW) ? COL_W : CoordW;
  localparam int unsigned CUR_RW     = (ROW_W > CoordW) ? ROW_W : CoordW;
  localparam int unsigned EC_W       = ($clog2(MAX_COLS + 1) > GridW) ?
                                       $clog2(MAX_COLS + 1) : GridW;
  localparam int unsigned ER_W       = ($clog2(MAX_ROWS + 1) > GridW) ?
                                       $clog2(MAX_ROWS + 1) : GridW;
  localparam int unsigned CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int unsigned VA_W       = COL_W + ROW_W;
  localparam int unsigned V_DEPTH    = 1 << VA_W;
  localparam int unsigned SA_W       = $clog2(CELL_COUNT);
  localparam int unsigned DEP_W      = $clog2(CELL_COUNT + 1);
  localparam int unsigned TOT_W      = EC_W + ER_W;
  localparam int unsigned CMP_W      = (TOT_W > DEP_W) ? TOT_W : DEP_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_RD,
    S_INIT_WR,
    S_SCAN,
    S_SCAN_LAST,
    S_EVAL,
    S_POP,
    S_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [VA_W-1:0]     clr_addr_q, clr_addr_d;
  logic [GridW-1:0]    grid_cols_q, grid_cols_d;
  logic [GridW-1:0]    grid_rows_q, grid_rows_d;
  logic [CoordW-1:0]   start_col_q, start_col_d;
  logic [CoordW-1:0]   start_row_q, start_row_d;
  logic                started_q, started_d;
  logic [CUR_CW-1:0]   cur_col_q, cur_col_d;
  logic [CUR_RW-1:0]   cur_row_q, cur_row_d;
  logic [DEP_W-1:0]    depth_q, depth_d;
  logic [DEP_W-1:0]    vcount_q, vcount_d;
  logic [RandW-1:0]    rand_q, rand_d;
  dir_t                scan_dir_q, scan_dir_d;
  logic                pend_q, pend_d;
  dir_t                pend_dir_q, pend_dir_d;
  logic [3:0]          mask_q, mask_d;
  // result waiting for the output register
  logic                res_carved_q, res_carved_d;
  logic [CoordW-1:0]   res_col_q, res_col_d;
  logic [CoordW-1:0]   res_row_q, res_row_d;
  dir_t                res_dir_q, res_dir_d;
  logic                res_done_q, res_done_d;
  // output register
  logic                out_valid_q, out_valid_d;
  logic                carved_q, carved_d;
  logic [CoordW-1:0]   from_col_q, from_col_d;
  logic [CoordW-1:0]   from_row_q, from_row_d;
  dir_t                wall_dir_q, wall_dir_d;
  logic                done_res_q, done_res_d;

  // ram ports
  logic                v_we, v_re;
  logic [VA_W-1:0]     v_waddr, v_raddr;
  logic [0:0]          v_wdata, v_rdata;
  logic                s_we, s_re;
  logic [SA_W-1:0]     s_waddr, s_raddr;
  logic [VA_W-1:0]     s_wdata, s_rdata;

  logic [EC_W-1:0]     eff_cols;
  logic [ER_W-1:0]     eff_rows;
  logic [TOT_W-1:0]    cell_total;
  logic                grid_full;
  logic                cur_in_grid;
  logic [VA_W-1:0]     cur_addr;
  logic [DEP_W-1:0]    depth_dec;
  logic [3:0]          nb_ok;
  logic [CUR_CW-1:0]   nb_col [4];
  logic [CUR_RW-1:0]   nb_row [4];
  logic [VA_W-1:0]     nb_addr [4];
  pick_t               pick;

  // zero counts as one, large values saturate
  always_comb begin
    if (grid_cols_q == '0) begin
      eff_cols = EC_W'(1);
    end else if (EC_W'(grid_cols_q) > EC_W'(MAX_COLS)) begin
      eff_cols = EC_W'(MAX_COLS);
    end else begin
      eff_cols = EC_W'(grid_cols_q);
    end
    if (grid_rows_q == '0) begin
      eff_rows = ER_W'(1);
    end else if (ER_W'(grid_rows_q) > ER_W'(MAX_ROWS)) begin
      eff_rows = ER_W'(MAX_ROWS);
    end else begin
      eff_rows = ER_W'(grid_rows_q);
    end
  end

  assign cell_total  = TOT_W'(eff_cols) * TOT_W'(eff_rows);
  assign grid_full   = CMP_W'(vcount_q) >= CMP_W'(cell_total);
  assign cur_in_grid = (EC_W'(cur_col_q) < eff_cols) && (ER_W'(cur_row_q) < eff_rows);
  assign cur_addr    = {cur_row_q[ROW_W-1:0], cur_col_q[COL_W-1:0]};
  assign depth_dec   = depth_q - DEP_W'(1);

  // the four neighbours of the current cell, valid only while the cell is in the grid
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      nb_col[d] = cur_col_q;
      nb_row[d] = cur_row_q;
      nb_ok[d]  = 1'b0;
      case (dir_t'(d))
        DIR_NORTH: begin
          nb_row[d] = cur_row_q - CUR_RW'(1);
          nb_ok[d]  = cur_in_grid && (cur_row_q != '0);
        end
        DIR_EAST: begin
          nb_col[d] = cur_col_q + CUR_CW'(1);
          nb_ok[d]  = cur_in_grid && ((EC_W'(cur_col_q) + EC_W'(1)) < eff_cols);
        end
        DIR_SOUTH: begin
          nb_row[d] = cur_row_q + CUR_RW'(1);
          nb_ok[d]  = cur_in_grid && ((ER_W'(cur_row_q) + ER_W'(1)) < eff_rows);
        end
        default: begin
          nb_col[d] = cur_col_q - CUR_CW'(1);
          nb_ok[d]  = cur_in_grid && (cur_col_q != '0);
        end
      endcase
      nb_addr[d] = {nb_row[d][ROW_W-1:0], nb_col[d][COL_W-1:0]};
    end
  end

  mdc_dir_pick u_dir_pick (
    .cand_mask_i (mask_q),
    .rand_pick_i (rand_q),
    .pick_o      (pick)
  );

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    grid_cols_d  = grid_cols_q;
    grid_rows_d  = grid_rows_q;
    start_col_d  = start_col_q;
    start_row_d  = start_row_q;
    started_d    = started_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    depth_d      = depth_q;
    vcount_d     = vcount_q;
    rand_d       = rand_q;
    scan_dir_d   = scan_dir_q;
    pend_d       = pend_q;
    pend_dir_d   = pend_dir_q;
    mask_d       = mask_q;
    res_carved_d = res_carved_q;
    res_col_d    = res_col_q;
    res_row_d    = res_row_q;
    res_dir_d    = res_dir_q;
    res_done_d   = res_done_q;
    out_valid_d  = out_valid_q;
    carved_d     = carved_q;
    from_col_d   = from_col_q;
    from_row_d   = from_row_q;
    wall_dir_d   = wall_dir_q;
    done_res_d   = done_res_q;

    v_we    = 1'b0;
    v_waddr = cur_addr;
    v_wdata = 1'b1;
    v_re    = 1'b0;
    v_raddr = cur_addr;
    s_we    = 1'b0;
    s_waddr = depth_q[SA_W-1:0];
    s_wdata = cur_addr;
    s_re    = 1'b0;
    s_raddr = depth_dec[SA_W-1:0];

    // result beat taken downstream
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRID_COLS: grid_cols_d = cfg_data_i[GridW-1:0];
        REG_GRID_ROWS: grid_rows_d = cfg_data_i[GridW-1:0];
        REG_START_COL: start_col_d = cfg_data_i[CoordW-1:0];
        REG_START_ROW: start_row_d = cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_CLEAR: begin
        v_we       = 1'b1;
        v_waddr    = clr_addr_q;
        v_wdata    = 1'b0;
        clr_addr_d = clr_addr_q + VA_W'(1);
        if (clr_addr_q == '1) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid_i) begin
          rand_d     = rand_pick_i;
          scan_dir_d = DIR_NORTH;
          pend_d     = 1'b0;
          mask_d     = '0;
          if (!started_q) begin
            started_d = 1'b1;
            cur_col_d = CUR_CW'(start_col_q);
            cur_row_d = CUR_RW'(start_row_q);
            state_d   = S_INIT_RD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // first step: mark the start cell
      S_INIT_RD: begin
        if (cur_in_grid) begin
          v_re    = 1'b1;
          state_d = S_INIT_WR;
        end else begin
          state_d = S_SCAN;
        end
      end

      S_INIT_WR: begin
        if (!v_rdata[0]) begin
          v_we     = 1'b1;
          vcount_d = vcount_q + DEP_W'(1);
        end
        state_d = S_SCAN;
      end

      // one neighbour read per cycle, data lands in the following cycle
      S_SCAN: begin
        if (pend_q && !v_rdata[0]) mask_d[pend_dir_q] = 1'b1;
        pend_d     = nb_ok[scan_dir_q];
        pend_dir_d = scan_dir_q;
        v_re       = nb_ok[scan_dir_q];
        v_raddr    = nb_addr[scan_dir_q];
        scan_dir_d = scan_dir_q + dir_t'(1);
        if (scan_dir_q == DIR_WEST) state_d = S_SCAN_LAST;
      end

      S_SCAN_LAST: begin
        if (pend_q && !v_rdata[0]) mask_d[pend_dir_q] = 1'b1;
        pend_d  = 1'b0;
        state_d = S_EVAL;
      end

      S_EVAL: begin
        if (grid_full || (!pick.found && depth_q == '0)) begin
          res_carved_d = 1'b0;
          res_col_d    = '0;
          res_row_d    = '0;
          res_dir_d    = DIR_NORTH;
          res_done_d   = 1'b1;
          state_d      = S_OUT;
        end else if (!pick.found) begin
          // dead end: backtrack one cell
          s_re    = 1'b1;
          depth_d = depth_dec;
          state_d = S_POP;
        end else begin
          if (depth_q < DEP_W'(CELL_COUNT)) begin
            s_we    = 1'b1;
            depth_d = depth_q + DEP_W'(1);
          end
          res_carved_d = 1'b1;
          res_col_d    = cur_col_q[CoordW-1:0];
          res_row_d    = cur_row_q[CoordW-1:0];
          res_dir_d    = pick.dir;
          res_done_d   = 1'b0;
          // chosen neighbour was read unvisited in this scan
          v_we         = 1'b1;
          v_waddr      = nb_addr[pick.dir];
          vcount_d     = vcount_q + DEP_W'(1);
          cur_col_d    = nb_col[pick.dir];
          cur_row_d    = nb_row[pick.dir];
          state_d      = S_OUT;
        end
      end

      S_POP: begin
        cur_col_d  = CUR_CW'(s_rdata[COL_W-1:0]);
        cur_row_d  = CUR_RW'(s_rdata[VA_W-1:COL_W]);
        scan_dir_d = DIR_NORTH;
        pend_d     = 1'b0;
        mask_d     = '0;
        state_d    = S_SCAN;
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          carved_d    = res_carved_q;
          from_col_d  = res_col_q;
          from_row_d  = res_row_q;
          wall_dir_d  = res_dir_q;
          done_res_d  = res_done_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      grid_cols_q  <= GridW'(32);
      grid_rows_q  <= GridW'(32);
      start_col_q  <= '0;
      start_row_q  <= '0;
      started_q    <= 1'b0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      depth_q      <= '0;
      vcount_q     <= '0;
      rand_q       <= '0;
      scan_dir_q   <= DIR_NORTH;
      pend_q       <= 1'b0;
      pend_dir_q   <= DIR_NORTH;
      mask_q       <= '0;
      res_carved_q <= 1'b0;
      res_col_q    <= '0;
      res_row_q    <= '0;
      res_dir_q    <= DIR_NORTH;
      res_done_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      carved_q     <= 1'b0;
      from_col_q   <= '0;
      from_row_q   <= '0;
      wall_dir_q   <= DIR_NORTH;
      done_res_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      grid_cols_q  <= grid_cols_d;
      grid_rows_q  <= grid_rows_d;
      start_col_q  <= start_col_d;
      start_row_q  <= start_row_d;
      started_q    <= started_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      depth_q      <= depth_d;
      vcount_q     <= vcount_d;
      rand_q       <= rand_d;
      scan_dir_q   <= scan_dir_d;
      pend_q       <= pend_d;
      pend_dir_q   <= pend_dir_d;
      mask_q       <= mask_d;
      res_carved_q <= res_carved_d;
      res_col_q    <= res_col_d;
      res_row_q    <= res_row_d;
      res_dir_q    <= res_dir_d;
      res_done_q   <= res_done_d;
      out_valid_q  <= out_valid_d;
      carved_q     <= carved_d;
      from_col_q   <= from_col_d;
      from_row_q   <= from_row_d;
      wall_dir_q   <= wall_dir_d;
      done_res_q   <= done_res_d;
    end
  end

  // one visited bit per cell
  mdc_ram #(
    .Width (1),
    .Depth (V_DEPTH)
  ) u_visited_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // backtrack stack of cell addresses
  mdc_ram #(
    .Width (VA_W),
    .Depth (CELL_COUNT)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign carved_o    = carved_q;
  assign from_col_o  = from_col_q;
  assign from_row_o  = from_row_q;
  assign wall_dir_o  = wall_dir_q;
  assign done_res_o  = done_res_q;

  `MDC_ASSERT(a_accept_goes_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "step accepted but block still idle")
  `MDC_ASSERT_ALWAYS(a_depth_bound, clk_i, !rst_ni || (depth_q <= DEP_W'(CELL_COUNT)), "stack depth beyond cell count")
  `MDC_ASSERT(a_result_kind, clk_i, rst_ni, out_valid_o |-> (carved_o != done_res_o), "result neither carve nor done")
  `MDC_ASSERT(a_count_step, clk_i, rst_ni, (vcount_q != $past(vcount_q)) |-> (vcount_q == DEP_W'($past(vcount_q) + 1'b1)), "visited count jumped")

endmodule

[src/mdc_ram.sv]
module mdc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/mdc_dir_pick.sv]
module mdc_dir_pick (
  input  logic [3:0]               cand_mask_i,
  input  logic [mdc_pkg::RandW-1:0] rand_pick_i,
  output mdc_pkg::pick_t           pick_o
);

  import mdc_pkg::*;

  logic [2:0] cand_cnt;
  logic [1:0] sel;
  logic [2:0] seen;

  // base-4 digit sum, since 4 is 1 mod 3
  function automatic logic [1:0] mod3(input logic [RandW-1:0] v);
    logic [3:0] s;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    if (s >= 4'd9) s = s - 4'd9;
    if (s >= 4'd6) s = s - 4'd6;
    if (s >= 4'd3) s = s - 4'd3;
    return s[1:0];
  endfunction

  assign cand_cnt = 3'($countones(cand_mask_i));

  always_comb begin
    case (cand_cnt)
      3'd2:    sel = {1'b0, rand_pick_i[0]};
      3'd3:    sel = mod3(rand_pick_i);
      3'd4:    sel = rand_pick_i[1:0];
      default: sel = 2'd0;
    endcase
  end

  // walk the mask in n, e, s, w order to the selected candidate
  always_comb begin
    seen         = 3'd0;
    pick_o.found = |cand_mask_i;
    pick_o.dir   = DIR_NORTH;
    for (int d = 0; d < 4; d++) begin
      if (cand_mask_i[d]) begin
        if (seen == {1'b0, sel}) pick_o.dir = dir_t'(d);
        seen = seen + 3'd1;
      end
    end
  end

endmodule
